@@ hw/rtl/pipt_pkg.sv @@
// ----------------------------------------------------------------------------
// pipt_pkg
// Shared types and constants for the point-in-polygon test core.
// ----------------------------------------------------------------------------
package pipt_pkg;

  localparam int unsigned LatW     = 31;
  localparam int unsigned LngW     = 32;
  localparam int unsigned CmdDepth = 4;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef logic signed [LatW-1:0] lat_t;
  typedef logic signed [LngW-1:0] lng_t;

  typedef struct packed {
    op_e  op;
    logic restart;
    lat_t lat;
    lng_t lng;
  } cmd_t;

endpackage

@@ hw/rtl/pipt_front.sv @@
// ----------------------------------------------------------------------------
// pipt_front
// Request intake: decodes each request into a command and queues it for the
// back end.
// ----------------------------------------------------------------------------
module pipt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic           req_type_i,
  input  logic           restart_i,
  input  pipt_pkg::lat_t coord_lat_i,
  input  pipt_pkg::lng_t coord_lng_i,
  output logic           cmd_valid_o,
  output pipt_pkg::cmd_t cmd_o,
  input  logic           cmd_ready_i
);
  import pipt_pkg::*;

  localparam int unsigned PtrW = $clog2(CmdDepth);

  cmd_t            fifo_q [CmdDepth];
  cmd_t            in_cmd;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            wr_en, rd_en;

  always_comb begin
    in_cmd.op      = req_type_i ? OP_QUERY : OP_LOAD;
    // restart only means something on a load
    in_cmd.restart = restart_i & ~req_type_i;
    in_cmd.lat     = coord_lat_i;
    in_cmd.lng     = coord_lng_i;
  end

  assign full_o      = (cnt_q == (PtrW+1)'(CmdDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign wr_en       = push_i & ~full_o;
  assign rd_en       = cmd_valid_o & cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    unique case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + (PtrW+1)'(1);
      2'b01:   cnt_d = cnt_q - (PtrW+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

@@ hw/rtl/pipt_back.sv @@
// ----------------------------------------------------------------------------
// pipt_back
// Command execution: vertex store, edge walk pipeline (read, difference,
// multiply, compare) and a two-entry result queue.
// ----------------------------------------------------------------------------
module pipt_back #(
  parameter int unsigned MaxVertices = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  pipt_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  output logic           res_valid_o,
  output logic           res_o,
  input  logic           res_ready_i
);
  import pipt_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxVertices);
  localparam int unsigned CntW  = $clog2(MaxVertices + 1);
  localparam int unsigned ProdW = LatW + LngW + 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // vertex store
  lat_t lat_mem [MaxVertices];
  lng_t lng_mem [MaxVertices];

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] eff_cnt;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            take, take_load, take_query, store_en, rd_en, rd_last;
  lat_t            last_lat_q, qlat_q, prev_lat_q, rd_lat_q;
  lng_t            last_lng_q, qlng_q, prev_lng_q, rd_lng_q;

  // pipeline
  logic                    s1_valid_q, s1_last_q;
  logic                    s2_valid_q, s2_last_q;
  logic                    s3_valid_q, s3_last_q;
  logic signed [LatW:0]    s2_a_q, s2_d_q;
  logic signed [LngW:0]    s2_b_q, s2_c_q;
  logic                    s2_bbox_q, s2_strad_q;
  logic signed [ProdW-1:0] s3_p_q, s3_q_q;
  logic                    s3_bbox_q, s3_strad_q, s3_dneg_q;
  logic                    s1_bbox, s1_strad, on_edge, crossing;
  logic                    hit_q, par_q;

  // result queue
  logic       oq_q [2];
  logic       oq_wr_q, oq_rd_q;
  logic [1:0] oq_cnt_q;
  logic       oq_room, res_push, res_bit, res_pop;

  assign oq_room     = (oq_cnt_q != 2'd2);
  assign cmd_ready_o = (state_q == ST_IDLE) && ((cmd_i.op == OP_LOAD) || oq_room);
  assign take        = cmd_valid_i & cmd_ready_o;
  assign take_load   = take & (cmd_i.op == OP_LOAD);
  assign take_query  = take & (cmd_i.op == OP_QUERY);
  assign eff_cnt     = cmd_i.restart ? '0 : count_q;
  assign store_en    = take_load && (eff_cnt < CntW'(MaxVertices));
  assign rd_en       = (state_q == ST_WALK);
  assign rd_last     = ((rd_cnt_q + CntW'(1)) == count_q);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rd_cnt_d = rd_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take_load) begin
          count_d = store_en ? eff_cnt + CntW'(1) : eff_cnt;
        end
        if (take_query && (count_q != '0)) begin
          state_d  = ST_WALK;
          rd_cnt_d = '0;
        end
      end
      ST_WALK: begin
        rd_cnt_d = rd_cnt_q + CntW'(1);
        if (rd_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s3_valid_q && s3_last_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rd_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_cnt_q <= rd_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      lat_mem[eff_cnt[AddrW-1:0]] <= cmd_i.lat;
      lng_mem[eff_cnt[AddrW-1:0]] <= cmd_i.lng;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_lat_q <= lat_mem[rd_cnt_q[AddrW-1:0]];
      rd_lng_q <= lng_mem[rd_cnt_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      last_lat_q <= cmd_i.lat;
      last_lng_q <= cmd_i.lng;
    end
    if (take_query) begin
      qlat_q <= cmd_i.lat;
      qlng_q <= cmd_i.lng;
    end
  end

  // S1: edge from previous to current vertex; closing edge comes first
  assign s1_bbox  = (((prev_lng_q <= qlng_q) && (qlng_q <= rd_lng_q)) ||
                     ((rd_lng_q <= qlng_q) && (qlng_q <= prev_lng_q))) &&
                    (((prev_lat_q <= qlat_q) && (qlat_q <= rd_lat_q)) ||
                     ((rd_lat_q <= qlat_q) && (qlat_q <= prev_lat_q)));
  assign s1_strad = (prev_lat_q > qlat_q) != (rd_lat_q > qlat_q);

  always_ff @(posedge clk_i) begin
    if (take_query) begin
      prev_lat_q <= last_lat_q;
      prev_lng_q <= last_lng_q;
    end else if (s1_valid_q) begin
      prev_lat_q <= rd_lat_q;
      prev_lng_q <= rd_lng_q;
    end
    if (s1_valid_q) begin
      s2_a_q     <= (LatW+1)'(qlat_q) - (LatW+1)'(prev_lat_q);
      s2_d_q     <= (LatW+1)'(rd_lat_q) - (LatW+1)'(prev_lat_q);
      s2_b_q     <= (LngW+1)'(rd_lng_q) - (LngW+1)'(prev_lng_q);
      s2_c_q     <= (LngW+1)'(qlng_q) - (LngW+1)'(prev_lng_q);
      s2_bbox_q  <= s1_bbox;
      s2_strad_q <= s1_strad;
    end
    // S2: cross product terms
    if (s2_valid_q) begin
      s3_p_q     <= ProdW'(s2_a_q) * ProdW'(s2_b_q);
      s3_q_q     <= ProdW'(s2_c_q) * ProdW'(s2_d_q);
      s3_bbox_q  <= s2_bbox_q;
      s3_strad_q <= s2_strad_q;
      s3_dneg_q  <= s2_d_q[LatW];
    end
  end

  // S3: sign of cross product; a straddling edge has nonzero dlat
  assign on_edge  = (s3_p_q == s3_q_q) & s3_bbox_q;
  assign crossing = s3_strad_q & (s3_dneg_q ? (s3_p_q < s3_q_q) : (s3_p_q > s3_q_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
      s3_valid_q <= 1'b0;
      s3_last_q  <= 1'b0;
      hit_q      <= 1'b0;
      par_q      <= 1'b0;
    end else begin
      s1_valid_q <= rd_en;
      s1_last_q  <= rd_en & rd_last;
      s2_valid_q <= s1_valid_q;
      s2_last_q  <= s1_last_q;
      s3_valid_q <= s2_valid_q;
      s3_last_q  <= s2_last_q;
      if (take_query) begin
        hit_q <= 1'b0;
        par_q <= 1'b0;
      end else if (s3_valid_q) begin
        hit_q <= hit_q | on_edge;
        par_q <= par_q ^ crossing;
      end
    end
  end

  // empty polygon answers at once
  assign res_push = (take_query && (count_q == '0)) || (s3_valid_q && s3_last_q);
  assign res_bit  = s3_valid_q & (hit_q | on_edge | (par_q ^ crossing));
  assign res_pop  = res_valid_o & res_ready_i;

  assign res_valid_o = (oq_cnt_q != 2'd0);
  assign res_o       = oq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        oq_wr_q <= ~oq_wr_q;
      end
      if (res_pop) begin
        oq_rd_q <= ~oq_rd_q;
      end
      unique case ({res_push, res_pop})
        2'b10:   oq_cnt_q <= oq_cnt_q + 2'd1;
        2'b01:   oq_cnt_q <= oq_cnt_q - 2'd1;
        default: oq_cnt_q <= oq_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      oq_q[oq_wr_q] <= res_bit;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxVertices))
    else $error("vertex count beyond capacity");

  a_oq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> oq_room || res_pop)
    else $error("result queue overflow");

  a_read_follows_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(state_q) == ST_WALK)
    else $error("vertex read outside edge walk");

  a_push_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && (state_q != ST_IDLE)) |-> state_q == ST_DRAIN)
    else $error("result produced mid walk");

  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> rd_cnt_q < count_q)
    else $error("walk index past vertex count");

endmodule

@@ hw/rtl/point_in_polygon_test_core.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// Ray-casting point-in-polygon test on fixed-point coordinates.
//
//   Channel  Handshake            Payload
//   -------  -------------------  ---------------------------------------------
//   request  push / full          req_type_i, restart_i, coord_lat_i, coord_lng_i
//   result   empty / pop          inside_res_o (queries only)
//
// Requests queue in a 4-deep command queue ahead of the executor.
// A load updates the vertex store; a query on stored vertices reads one
// edge per cycle from the vertex store, then runs a three-stage
// difference/multiply/compare tail; with no vertices it is answered at once.
// Reset clears the vertex count and both queues; the vertex store is not cleared.
// A query starts only with a free slot in the 2-entry result queue.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic           req_type_i,
  input  logic           restart_i,
  input  pipt_pkg::lat_t coord_lat_i,
  input  pipt_pkg::lng_t coord_lng_i,
  output logic           empty,
  input  logic           pop,
  output logic           inside_res_o
);
  import pipt_pkg::*;

  logic cmd_valid, cmd_ready, res_valid;
  cmd_t cmd;

  pipt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_type_i  (req_type_i),
    .restart_i   (restart_i),
    .coord_lat_i (coord_lat_i),
    .coord_lng_i (coord_lng_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  pipt_back #(
    .MaxVertices (MAX_VERTICES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_o       (inside_res_o),
    .res_ready_i (pop)
  );

  assign empty = ~res_valid;

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Randomised check of point_in_polygon_test_core: polygons are loaded and
// queried through the request queue, each inside/outside verdict is predicted
// from a local copy of the vertex store, and the results are compared in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pipt_pkg::*;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned RandomItems = 1750;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 100;
  localparam longint      LatMin      = -(64'sd1 <<< 30);
  localparam longint      LatMax      = (64'sd1 <<< 30) - 1;
  localparam longint      LngMin      = -(64'sd1 <<< 31);
  localparam longint      LngMax      = (64'sd1 <<< 31) - 1;

  typedef struct {
    op_e  op;
    logic restart;
    lat_t lat;
    lng_t lng;
    bit   hold;
  } pipt_req_t;

  typedef struct {
    logic hit;
    lat_t lat;
    lng_t lng;
  } verdict_t;

  logic clk_i        = 1'b0;
  logic rst_ni       = 1'b0;
  logic push         = 1'b0;
  logic req_type_i   = 1'b0;
  logic restart_i    = 1'b0;
  lat_t coord_lat_i  = '0;
  lng_t coord_lng_i  = '0;
  logic pop          = 1'b0;
  logic full;
  logic empty;
  logic inside_res_o;

  pipt_req_t   item_q[$];
  verdict_t    verdict_q[$];
  int unsigned total_items;
  int unsigned accepted     = 0;
  int unsigned queries_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned phase        = 0;
  int unsigned idle_cycles  = 0;

  // predictor copy of the vertex store
  lat_t        vtx_lat[MaxVertices];
  lng_t        vtx_lng[MaxVertices];
  int unsigned vtx_count = 0;

  // generator view of the polygon being built
  longint poly_lat[$];
  longint poly_lng[$];
  longint grid_lat;
  longint grid_lng;
  longint grid_step;
  bit     grid_raw;

  point_in_polygon_test_core #(
    .MAX_VERTICES(MaxVertices)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_type_i  (req_type_i),
    .restart_i   (restart_i),
    .coord_lat_i (coord_lat_i),
    .coord_lng_i (coord_lng_i),
    .empty       (empty),
    .pop         (pop),
    .inside_res_o(inside_res_o)
  );

  always #6 clk_i = ~clk_i;

  // exact cross products in 128 bits, no division
  function automatic logic point_inside(lat_t qlat, lng_t qlng);
    logic signed [127:0] plat, plng, lat1, lng1, lat2, lng2, dlat, cp, cq;
    int unsigned i, j, crossings;
    crossings = 0;
    if (vtx_count == 0) return 1'b0;
    plat = qlat;
    plng = qlng;
    for (i = 0; i < vtx_count; i++) begin
      j = (i + 1 == vtx_count) ? 0 : i + 1;
      lat1 = vtx_lat[i];
      lng1 = vtx_lng[i];
      lat2 = vtx_lat[j];
      lng2 = vtx_lng[j];
      dlat = lat2 - lat1;
      cp = (plat - lat1) * (lng2 - lng1);
      cq = (plng - lng1) * dlat;
      if (cp == cq &&
          ((lng1 <= plng && plng <= lng2) || (lng2 <= plng && plng <= lng1)) &&
          ((lat1 <= plat && plat <= lat2) || (lat2 <= plat && plat <= lat1)))
        return 1'b1;
      if ((lat1 > plat) != (lat2 > plat) &&
          ((dlat > 0 && cp > cq) || (dlat < 0 && cp < cq)))
        crossings++;
    end
    return crossings[0];
  endfunction

  function automatic bit idle_roll(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic longint signed_range(int unsigned r);
    return longint'($urandom_range(2 * r)) - longint'(r);
  endfunction

  function automatic void add_req(op_e op, bit restart, longint lat, longint lng,
                                  bit hold = 1'b0);
    pipt_req_t r;
    r.op      = op;
    r.restart = restart;
    r.lat     = lat_t'(lat);
    r.lng     = lng_t'(lng);
    r.hold    = hold;
    item_q.push_back(r);
  endfunction

  function automatic void add_vertex(bit restart, bit hold);
    lat_t la;
    lng_t ln;
    if (grid_raw) begin
      la = lat_t'($urandom());
      ln = lng_t'($urandom());
    end else begin
      la = lat_t'(grid_lat + grid_step * signed_range(8));
      ln = lng_t'(grid_lng + grid_step * signed_range(8));
    end
    poly_lat.push_back(longint'(la));
    poly_lng.push_back(longint'(ln));
    add_req(OP_LOAD, restart, la, ln, hold);
  endfunction

  function automatic void add_polygon(int unsigned n, bit restart, bit hold);
    int unsigned k;
    poly_lat.delete();
    poly_lng.delete();
    grid_raw = ($urandom_range(9) == 0);
    case ($urandom_range(4))
      0:       grid_step = 1;
      1:       grid_step = 2;
      2:       grid_step = 1000;
      3:       grid_step = 64'sd1 <<< 20;
      default: grid_step = 64'sd1 <<< 26;
    endcase
    grid_lat = $urandom_range(1) ? 0 : longint'(lat_t'($urandom()));
    grid_lng = $urandom_range(1) ? 0 : longint'(lng_t'($urandom()));
    for (k = 0; k < n; k++) add_vertex(restart && k == 0, hold && k == 0);
  endfunction

  function automatic void add_query(bit restart);
    longint la, ln;
    int unsigned i, j, n;
    n = poly_lat.size();
    i = (n > 0) ? $urandom_range(n - 1) : 0;
    j = (i + 1 >= n) ? 0 : i + 1;
    la = grid_lat + grid_step * signed_range(9);
    ln = grid_lng + grid_step * signed_range(9);
    case ($urandom_range(6))
      0: if (n > 0) begin
        la = poly_lat[i];
        ln = poly_lng[i];
      end
      1, 2: if (n > 0) begin
        la = (poly_lat[i] + poly_lat[j]) >>> 1;
        ln = (poly_lng[i] + poly_lng[j]) >>> 1;
      end
      3: begin
        la = la + signed_range(1);
        ln = ln + signed_range(1);
      end
      4: begin
        la = longint'(lat_t'($urandom()));
        ln = longint'(lng_t'($urandom()));
      end
      5: begin
        la = $urandom_range(1) ? LatMin : LatMax;
        ln = $urandom_range(1) ? LngMin : LngMax;
      end
      default: ;
    endcase
    add_req(OP_QUERY, restart, la, ln);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    pipt_req_t r;
    int unsigned pct;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        r = item_q.pop_front();
        if (r.op == OP_LOAD) begin
          if (r.restart) vtx_count = 0;
          if (vtx_count < MaxVertices) begin
            vtx_lat[vtx_count] = r.lat;
            vtx_lng[vtx_count] = r.lng;
            vtx_count++;
          end
        end else begin
          verdict_q.push_back('{hit: point_inside(r.lat, r.lng), lat: r.lat, lng: r.lng});
          queries_sent = queries_sent + 1;
        end
        accepted <= accepted + 1;
        phase    <= ((accepted + 1) * 3 / total_items > 2) ? 2 :
                    (accepted + 1) * 3 / total_items;
      end
      pct = (phase == 0) ? 15 : (phase == 1) ? 69 : 0;
      if (!push || !full) begin
        if (item_q.size() == 0 || idle_roll(pct) ||
            (item_q[0].hold && queries_sent != results_seen)) begin
          push <= 1'b0;
        end else begin
          push        <= 1'b1;
          req_type_i  <= item_q[0].op;
          restart_i   <= item_q[0].restart;
          coord_lat_i <= item_q[0].lat;
          coord_lng_i <= item_q[0].lng;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t v;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (verdict_q.size() == 0) begin
          if (mismatches < 100)
            $display("%0t: inside_res expected none, actual %0b", $time, inside_res_o);
          mismatches++;
        end else begin
          v = verdict_q.pop_front();
          if (inside_res_o !== v.hit) begin
            if (mismatches < 100)
              $display("%0t: inside_res at (%0d, %0d) expected %0b, actual %0b",
                       $time, v.lat, v.lng, v.hit, inside_res_o);
            mismatches++;
          end
        end
      end
      pop <= !idle_roll((phase == 0) ? 69 : (phase == 1) ? 15 : 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned roll, n;
    // empty store, then a single vertex
    add_req(OP_QUERY, 1'b0, 0, 0);
    add_req(OP_LOAD, 1'b1, 5, -7);
    add_req(OP_QUERY, 1'b0, 5, -7);
    add_req(OP_QUERY, 1'b0, 6, -7);
    // square: centre, edge, corner, just outside, restart on a query
    add_req(OP_LOAD, 1'b1, -10, -10);
    add_req(OP_LOAD, 1'b0, -10, 10);
    add_req(OP_LOAD, 1'b0, 10, 10);
    add_req(OP_LOAD, 1'b0, 10, -10);
    add_req(OP_QUERY, 1'b0, 0, 0);
    add_req(OP_QUERY, 1'b0, 10, 0);
    add_req(OP_QUERY, 1'b0, 10, 10);
    add_req(OP_QUERY, 1'b0, 11, 0);
    add_req(OP_QUERY, 1'b0, 0, -11);
    add_req(OP_QUERY, 1'b1, 0, 0);
    // full-scale triangle, loaded only once the square answers are back
    add_req(OP_LOAD, 1'b1, LatMin, LngMin, 1'b1);
    add_req(OP_LOAD, 1'b0, LatMax, LngMin);
    add_req(OP_LOAD, 1'b0, 0, LngMax);
    add_req(OP_QUERY, 1'b0, 0, 0);
    add_req(OP_QUERY, 1'b0, LatMax, LngMax);
    add_req(OP_QUERY, 1'b0, LatMin, LngMax);
    add_req(OP_QUERY, 1'b0, LatMin, LngMin);

    total_items = item_q.size() + RandomItems;
    while (item_q.size() < total_items) begin
      roll = $urandom_range(99);
      if (roll < 85) begin
        case ($urandom_range(19))
          0, 1, 2:  n = $urandom_range(2, 1);
          3, 4:     n = $urandom_range(40, 9);
          5:        n = $urandom_range(70, 60);
          default:  n = $urandom_range(8, 3);
        endcase
        add_polygon(n, $urandom_range(19) != 0, $urandom_range(29) == 0);
        repeat ($urandom_range(6, 1)) add_query($urandom_range(9) == 0);
      end else if (roll < 92) begin
        add_vertex($urandom_range(3) == 0, 1'b0);
      end else begin
        add_query($urandom_range(1));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (item_q.size() != 0 || queries_sent != results_seen) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (verdict_q.size() != 0)
      $display("%0t: %0d inside_res results expected, none arrived", $time, verdict_q.size());
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ point_in_polygon_test_core.f @@
hw/rtl/pipt_pkg.sv
hw/rtl/pipt_front.sv
hw/rtl/pipt_back.sv
hw/rtl/point_in_polygon_test_core.sv
bench/testbench.sv
